@@ rtl/dma_slice_bitmap_allocator_assert.svh @@
// assertion macros shared by the slice allocator modules
// depends on nothing; included by the modules that carry assertions
`ifndef DMA_SLICE_BITMAP_ALLOCATOR_ASSERT_SVH
`define DMA_SLICE_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DSBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DSBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dsba_pkg.sv @@
// shared widths, codes and controller/datapath link types of the slice allocator
// depends on nothing
package dsba_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 64;
  localparam int BLK_W      = 25;
  localparam int SLB_W      = 17;
  localparam int SCNT_W     = 9;
  localparam int STAT_W     = 3;
  localparam int SLOT_W     = 8;

  // bitmap bits examined per scan cycle
  localparam int CHUNK      = 16;
  localparam int CHUNK_LG   = 4;

  // register reset values
  localparam logic [BLK_W-1:0]  RST_BLOCK_BYTES = 25'd4096;
  localparam logic [SLB_W-1:0]  RST_SLICE_BYTES = 17'd64;
  localparam logic [SCNT_W-1:0] RST_SLICE_COUNT = 9'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIRT_BASE   = 3'd0,
    CFG_PHYS_BASE   = 3'd1,
    CFG_BLOCK_BYTES = 3'd2,
    CFG_SLICE_BYTES = 3'd3,
    CFG_SLICE_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_NOT_SET    = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic mul;
    logic range_chk;
    logic check;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_free;
    logic hit;
    logic last_chunk;
    logic range_fail;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/dsba_ifs.sv @@
// request and response channel interfaces of the slice allocator
// depends on dsba_pkg
interface dsba_req_if;
  import dsba_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output opcode, output free_address, input ready);
  modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

interface dsba_rsp_if;
  import dsba_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_index;
  logic [ADDR_W-1:0] virt_addr;
  logic [ADDR_W-1:0] phys_addr;

  modport source (output valid, output status, output slot_index, output virt_addr,
                  output phys_addr, input ready);
  modport sink   (input valid, input status, input slot_index, input virt_addr,
                  input phys_addr, output ready);
endinterface

@@ rtl/dsba_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on dsba_pkg and dma_slice_bitmap_allocator_assert.svh
`include "dma_slice_bitmap_allocator_assert.svh"

module dsba_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dsba_pkg::BLK_W-1:0] dividend,
  input  logic [dsba_pkg::SLB_W-1:0] divisor,
  output logic                       busy,
  output logic [dsba_pkg::BLK_W-1:0] quot,
  output logic [dsba_pkg::SLB_W-1:0] rem
);
  import dsba_pkg::*;

  localparam int CNT_W = $clog2(BLK_W);

  logic [CNT_W-1:0] cnt;
  logic [BLK_W-1:0] dq;
  logic [SLB_W-1:0] rem_q;
  logic [SLB_W-1:0] dvsr;
  logic [SLB_W:0]   rem_sh;
  logic             fits;
  logic [SLB_W:0]   rem_sub;

  // trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh  = {rem_q, dq[BLK_W-1]};
    fits    = rem_sh >= {1'b0, dvsr};
    rem_sub = rem_sh - {1'b0, dvsr};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(BLK_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      rem_q <= '0;
      dvsr  <= divisor;
    end else if (busy) begin
      dq    <= {dq[BLK_W-2:0], fits};
      rem_q <= fits ? rem_sub[SLB_W-1:0] : rem_sh[SLB_W-1:0];
    end
  end

  assign quot = dq;
  assign rem  = rem_q;

  `DSBA_ASSERT_IMP(a_rem_below_divisor, clk, rst, $fell(busy), rem_q < dvsr, "remainder not below divisor")

endmodule

@@ rtl/dsba_dp.sv @@
// datapath: config registers, used-slice bitmap, chunked free-slot scan,
// address offset multiply, range check, divider and result register
// depends on dsba_pkg, dsba_div and dma_slice_bitmap_allocator_assert.svh
`include "dma_slice_bitmap_allocator_assert.svh"

module dsba_dp #(
  parameter int MAX_SLICES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dsba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_opcode,
  input  logic [dsba_pkg::ADDR_W-1:0]     in_free_address,
  input  dsba_pkg::dp_cmd_t               cmd,
  output dsba_pkg::dp_stat_t              st,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dsba_pkg::STAT_W-1:0]     out_status,
  output logic [dsba_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [dsba_pkg::ADDR_W-1:0]     out_virt_addr,
  output logic [dsba_pkg::ADDR_W-1:0]     out_phys_addr
);
  import dsba_pkg::*;

  localparam int NUM_CHUNKS = (MAX_SLICES + CHUNK - 1) / CHUNK;
  localparam int MAP_W      = NUM_CHUNKS * CHUNK;
  localparam int CHW_R      = $clog2(NUM_CHUNKS);
  localparam int IDX_W      = CHW_R + CHUNK_LG;
  localparam int CW         = (CHW_R > 0) ? CHW_R : 1;
  localparam int NW         = IDX_W + 1;
  localparam int OFF_W      = SLB_W + IDX_W;

  // config registers
  logic [ADDR_W-1:0] virt_base;
  logic [ADDR_W-1:0] phys_base;
  logic [BLK_W-1:0]  block_bytes;
  logic [SLB_W-1:0]  slice_bytes;
  logic [SCNT_W-1:0] slice_count;

  // item state
  logic [MAP_W-1:0]  map;
  logic              op_free;
  logic [ADDR_W-1:0] addr;
  logic [CW-1:0]     chunk_cnt;
  logic [IDX_W-1:0]  slot;
  status_t           res_status;
  logic [OFF_W-1:0]  off_q;

  // combinational
  logic [NW-1:0]       n;
  logic [CHUNK-1:0]    chunk_bits;
  logic [CHUNK-1:0]    free_bits;
  logic [IDX_W-1:0]    chunk_base;
  logic [IDX_W-1:0]    slot_k;
  logic [CHUNK_LG-1:0] pe;
  logic                hit;
  logic [IDX_W-1:0]    hit_slot;
  logic [ADDR_W:0]     diff;
  logic [ADDR_W-1:0]   off;
  logic                outside;
  logic                sb_zero;
  logic                div_busy;
  logic [BLK_W-1:0]    quot;
  logic [SLB_W-1:0]    rem;
  logic                res_ok;

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      virt_base   <= '0;
      phys_base   <= '0;
      block_bytes <= RST_BLOCK_BYTES;
      slice_bytes <= RST_SLICE_BYTES;
      slice_count <= RST_SLICE_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VIRT_BASE:   virt_base   <= cfg_data;
        CFG_PHYS_BASE:   phys_base   <= cfg_data;
        CFG_BLOCK_BYTES: block_bytes <= cfg_data[BLK_W-1:0];
        CFG_SLICE_BYTES: slice_bytes <= cfg_data[SLB_W-1:0];
        CFG_SLICE_COUNT: slice_count <= cfg_data[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // usable slice count, clamped to the bitmap size
  assign n = (slice_count > MAX_SLICES) ? NW'(MAX_SLICES) : NW'(slice_count);

  // lowest free slot inside the current chunk
  always_comb begin
    chunk_bits = map[chunk_cnt*CHUNK +: CHUNK];
    chunk_base = IDX_W'(chunk_cnt) << CHUNK_LG;
    slot_k     = '0;
    pe         = '0;
    for (int k = 0; k < CHUNK; k++) begin
      slot_k       = chunk_base | IDX_W'(k);
      free_bits[k] = !chunk_bits[k] && ({1'b0, slot_k} < n);
    end
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (free_bits[k]) begin
        pe = CHUNK_LG'(k);
      end
    end
    hit      = |free_bits;
    hit_slot = chunk_base | IDX_W'(pe);
  end

  // free address against the block bounds
  always_comb begin
    diff    = {1'b0, addr} - {1'b0, virt_base};
    off     = diff[ADDR_W-1:0];
    outside = diff[ADDR_W] || (off >= ADDR_W'(block_bytes));
    sb_zero = (slice_bytes == '0);
  end

  // offset to slot index and alignment remainder
  dsba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.range_chk && !outside && !sb_zero),
    .dividend (off[BLK_W-1:0]),
    .divisor  (slice_bytes),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign res_ok = (res_status == ST_OK);

  // status toward the controller
  always_comb begin
    st.in_free    = (in_opcode == OP_FREE);
    st.hit        = hit;
    st.last_chunk = (chunk_cnt == CW'(NUM_CHUNKS - 1));
    st.range_fail = outside || sb_zero;
    st.div_busy   = div_busy;
    st.out_free   = !out_valid || out_ready;
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_free    <= (in_opcode == OP_FREE);
      addr       <= in_free_address;
      chunk_cnt  <= '0;
      res_status <= ST_OK;
    end
    if (cmd.scan) begin
      if (hit) begin
        slot       <= hit_slot;
        res_status <= ST_OK;
      end else if (st.last_chunk) begin
        res_status <= ST_FULL;
      end else begin
        chunk_cnt <= chunk_cnt + 1'b1;
      end
    end
    if (cmd.mul) begin
      off_q <= OFF_W'(slice_bytes) * OFF_W'(slot);
    end
    if (cmd.range_chk) begin
      if (outside) begin
        res_status <= ST_NOT_FOUND;
      end else if (sb_zero) begin
        res_status <= ST_MISALIGNED;
      end
    end
    if (cmd.check) begin
      if (rem != '0) begin
        res_status <= ST_MISALIGNED;
      end else if (quot >= BLK_W'(n)) begin
        res_status <= ST_NOT_SET;
      end else if (!map[quot[IDX_W-1:0]]) begin
        res_status <= ST_NOT_SET;
      end else begin
        res_status <= ST_OK;
        slot       <= quot[IDX_W-1:0];
      end
    end
  end

  // used-slice bitmap, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      map <= '0;
    end else if (cmd.commit && res_ok) begin
      map[slot] <= !op_free;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status     <= res_status;
      out_slot_index <= res_ok ? SLOT_W'(slot) : '0;
      out_virt_addr  <= (res_ok && !op_free) ? virt_base + ADDR_W'(off_q) : '0;
      out_phys_addr  <= (res_ok && !op_free) ? phys_base + ADDR_W'(off_q) : '0;
    end
  end

  `DSBA_ASSERT_IMP(a_hit_in_range, clk, rst, cmd.scan && hit, {1'b0, hit_slot} < n, "scan picked a slot past the count")
  `DSBA_ASSERT_NXT(a_alloc_marks, clk, rst, cmd.commit && res_ok && !op_free, map[$past(slot)], "allocated slot not marked used")

endmodule

@@ rtl/dsba_ctrl.sv @@
// controller state machine sequencing allocate and free items
// depends on dsba_pkg and dma_slice_bitmap_allocator_assert.svh
`include "dma_slice_bitmap_allocator_assert.svh"

module dsba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dsba_pkg::dp_stat_t st,
  output dsba_pkg::dp_cmd_t  cmd
);
  import dsba_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_RANGE = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = st.in_free ? S_RANGE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          state_next = S_MUL;
        end else if (st.last_chunk) begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DONE;
      end
      S_RANGE: begin
        cmd.range_chk = 1'b1;
        state_next    = st.range_fail ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `DSBA_ASSERT_IMP(a_commit_free, clk, rst, cmd.commit, st.out_free, "result written over an untaken item")
  `DSBA_ASSERT_IMP(a_load_idle, clk, rst, cmd.load, !cmd.commit && state == S_IDLE, "item taken outside idle")

endmodule

@@ rtl/dma_slice_bitmap_allocator.sv @@
// top level of the DMA slice allocator: controller plus datapath
// depends on dsba_pkg, dsba_ifs, dsba_ctrl and dsba_dp
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   opcode, free_address
//   rsp      out  valid/ready   status, slot_index, virt_addr, phys_addr
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// allocate: k = 1..ceil(MAX_SLICES/16) chunk scans of the bitmap by the
// 16-bit-per-cycle free-slot scan, then, on a hit, the slice offset multiply
// free: an in-range address goes through the 25-step offset divider;
// an address outside the block or a zero slice size skips the divider
// reset clears the bitmap at once; no clearing pass
// a result waits in the output register while the next item is accepted

module dma_slice_bitmap_allocator #(
  parameter int MAX_SLICES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dsba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsba_pkg::CFG_DATA_W-1:0] cfg_data,
  dsba_req_if.sink                        req,
  dsba_rsp_if.source                      rsp
);
  import dsba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     req_ready;

  assign req.ready = req_ready;

  dsba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  dsba_dp #(
    .MAX_SLICES (MAX_SLICES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (req.opcode),
    .in_free_address (req.free_address),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_slot_index  (rsp.slot_index),
    .out_virt_addr   (rsp.virt_addr),
    .out_phys_addr   (rsp.phys_addr)
  );

endmodule
